[hw/rtl/led_blink_pattern_generator_defines.svh]
// Assertion macros shared by the LED blink pattern generator RTL.
// Depends on nothing; the asserting module supplies clk and rst_n.
`ifndef LED_BLINK_PATTERN_GENERATOR_DEFINES_SVH
`define LED_BLINK_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lbpg_pkg.sv]
// Package for the LED blink pattern generator: widths, mode codes,
// register indexes and reset values. Depends on nothing.
`timescale 1ns / 1ps

package lbpg_pkg;

  localparam int DURATION_BITS = 15;
  localparam int CNT_W         = DURATION_BITS + 2;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 5;
  localparam int TDATA_W       = 8;

  typedef logic [DURATION_BITS-1:0] dur_t;
  typedef logic signed [CNT_W-1:0]  cnt_t;

  // Largest counter value; an increment saturates here.
  localparam cnt_t CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

  typedef enum logic [3:0] {
    MODE_OFF       = 4'd0,
    MODE_ON        = 4'd1,
    MODE_SINGLE    = 4'd2,
    MODE_DOUBLE    = 4'd3,
    MODE_TRIPLE    = 4'd4,
    MODE_FAST      = 4'd5,
    MODE_BLINK     = 4'd6,
    MODE_SLOW      = 4'd7,
    MODE_BLIP      = 4'd8,
    MODE_SLOW_BLIP = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    REG_BLINK_HALF      = 3'd0,
    REG_FAST_HALF       = 3'd1,
    REG_SLOW_HALF       = 3'd2,
    REG_PULSE_LEN       = 3'd3,
    REG_BLIP_ON         = 3'd4,
    REG_BLIP_PAUSE      = 3'd5,
    REG_SLOW_BLIP_ON    = 3'd6,
    REG_SLOW_BLIP_PAUSE = 3'd7
  } reg_idx_t;

  localparam dur_t RST_BLINK_HALF      = dur_t'(50);
  localparam dur_t RST_FAST_HALF       = dur_t'(25);
  localparam dur_t RST_SLOW_HALF       = dur_t'(100);
  localparam dur_t RST_PULSE_LEN       = dur_t'(50);
  localparam dur_t RST_BLIP_ON         = dur_t'(2);
  localparam dur_t RST_BLIP_PAUSE      = dur_t'(100);
  localparam dur_t RST_SLOW_BLIP_ON    = dur_t'(2);
  localparam dur_t RST_SLOW_BLIP_PAUSE = dur_t'(300);

  // Zero-extends an unsigned duration into the signed counter width.
  function automatic cnt_t dur_to_cnt(input dur_t d);
    return cnt_t'({2'b00, d});
  endfunction

endpackage

[hw/rtl/led_blink_pattern_generator.sv]
// LED blink pattern generator top level: request streams, APB registers
// and the pattern state. Depends on lbpg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "led_blink_pattern_generator_defines.svh"

// The block drives one LED from a pattern mode and a signed phase counter.
// A request with in_tuser high loads the mode in in_tdata[3:0] (0 off, 1 on,
// 2 single, 3 double, 4 triple, 5 fast, 6 blink, 7 slow, 8 blip, 9 slow
// blip) and returns nothing; a request with in_tuser low is one tick and
// returns exactly one result, the LED level in out_tdata[0]. The mode and
// counter update in the cycle the request is accepted and the level lands in
// the output register on the same edge, so one request per cycle is
// sustained as long as the result side keeps taking results. The output
// register is the only buffer, so in_tready falls only while a result
// waits and out_tready is low. Timing registers sit on the APB port at
// byte addresses 4*i and should be written while the stream is idle.
module led_blink_pattern_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input request stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lbpg_pkg::TDATA_W-1:0]     in_tdata,   // [3:0] new_mode, [7:4] zero
  input  logic                             in_tuser,   // [0] kind: 1 load mode, 0 tick
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lbpg_pkg::TDATA_W-1:0]     out_tdata,  // [0] led_level, [7:1] zero
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lbpg_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [lbpg_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [lbpg_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  // Timing registers.
  lbpg_pkg::dur_t blink_half_r, fast_half_r, slow_half_r, pulse_len_r;
  lbpg_pkg::dur_t blip_on_r, blip_pause_r, slow_blip_on_r, slow_blip_pause_r;

  // Pattern state.
  lbpg_pkg::mode_t mode_r, mode_nxt;
  lbpg_pkg::cnt_t  cnt_r, cnt_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic led_r, led_nxt;

  logic             in_fire;
  logic             tick_fire;
  logic             cfg_wr;
  lbpg_pkg::reg_idx_t cfg_idx;
  lbpg_pkg::dur_t   cfg_val;
  lbpg_pkg::cnt_t   cnt_inc;
  lbpg_pkg::dur_t   wrap_lim, wrap_rst;
  logic             led_tick;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = lbpg_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_val    = cfg_pwdata[lbpg_pkg::DURATION_BITS-1:0];

  // A request may enter whenever the output register is empty or drains now.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign tick_fire = in_fire && !in_tuser;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lbpg_pkg::TDATA_W-1){1'b0}}, led_r};

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_half_r      <= lbpg_pkg::RST_BLINK_HALF;
      fast_half_r       <= lbpg_pkg::RST_FAST_HALF;
      slow_half_r       <= lbpg_pkg::RST_SLOW_HALF;
      pulse_len_r       <= lbpg_pkg::RST_PULSE_LEN;
      blip_on_r         <= lbpg_pkg::RST_BLIP_ON;
      blip_pause_r      <= lbpg_pkg::RST_BLIP_PAUSE;
      slow_blip_on_r    <= lbpg_pkg::RST_SLOW_BLIP_ON;
      slow_blip_pause_r <= lbpg_pkg::RST_SLOW_BLIP_PAUSE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lbpg_pkg::REG_BLINK_HALF:      blink_half_r      <= cfg_val;
        lbpg_pkg::REG_FAST_HALF:       fast_half_r       <= cfg_val;
        lbpg_pkg::REG_SLOW_HALF:       slow_half_r       <= cfg_val;
        lbpg_pkg::REG_PULSE_LEN:       pulse_len_r       <= cfg_val;
        lbpg_pkg::REG_BLIP_ON:         blip_on_r         <= cfg_val;
        lbpg_pkg::REG_BLIP_PAUSE:      blip_pause_r      <= cfg_val;
        lbpg_pkg::REG_SLOW_BLIP_ON:    slow_blip_on_r    <= cfg_val;
        lbpg_pkg::REG_SLOW_BLIP_PAUSE: slow_blip_pause_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    lbpg_pkg::dur_t rd;
    rd = '0;
    unique case (cfg_idx)
      lbpg_pkg::REG_BLINK_HALF:      rd = blink_half_r;
      lbpg_pkg::REG_FAST_HALF:       rd = fast_half_r;
      lbpg_pkg::REG_SLOW_HALF:       rd = slow_half_r;
      lbpg_pkg::REG_PULSE_LEN:       rd = pulse_len_r;
      lbpg_pkg::REG_BLIP_ON:         rd = blip_on_r;
      lbpg_pkg::REG_BLIP_PAUSE:      rd = blip_pause_r;
      lbpg_pkg::REG_SLOW_BLIP_ON:    rd = slow_blip_on_r;
      lbpg_pkg::REG_SLOW_BLIP_PAUSE: rd = slow_blip_pause_r;
      default:                       rd = '0;
    endcase
    cfg_prdata = {{(lbpg_pkg::CFG_DATA_W-lbpg_pkg::DURATION_BITS){1'b0}}, rd};
  end

  // The counter saturates at its top value instead of wrapping.
  assign cnt_inc = (cnt_r < lbpg_pkg::CNT_MAX) ? cnt_r + lbpg_pkg::cnt_t'(1) : cnt_r;

  // The symmetric blink and blip modes share one wrap compare; this picks the
  // limit that ends the dark phase and the on-time the counter restarts from.
  always_comb begin
    wrap_lim = blink_half_r;
    wrap_rst = blink_half_r;
    case (mode_r)
      lbpg_pkg::MODE_FAST: begin
        wrap_lim = fast_half_r;
        wrap_rst = fast_half_r;
      end
      lbpg_pkg::MODE_SLOW: begin
        wrap_lim = slow_half_r;
        wrap_rst = slow_half_r;
      end
      lbpg_pkg::MODE_BLIP: begin
        wrap_lim = blip_pause_r;
        wrap_rst = blip_on_r;
      end
      lbpg_pkg::MODE_SLOW_BLIP: begin
        wrap_lim = slow_blip_pause_r;
        wrap_rst = slow_blip_on_r;
      end
      default: begin
        wrap_lim = blink_half_r;
        wrap_rst = blink_half_r;
      end
    endcase
  end

  // Next mode and counter.
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    if (in_fire && in_tuser) begin
      // Loading a mode presets the counter to minus its first on-time. Fast
      // blink starts with the normal blink length. Off, on, slow blink and
      // undefined codes leave the counter as it is.
      mode_nxt = lbpg_pkg::mode_t'(in_tdata[3:0]);
      unique case (lbpg_pkg::mode_t'(in_tdata[3:0])) inside
        lbpg_pkg::MODE_BLINK, lbpg_pkg::MODE_FAST:
          cnt_nxt = -lbpg_pkg::dur_to_cnt(blink_half_r);
        lbpg_pkg::MODE_SINGLE, lbpg_pkg::MODE_DOUBLE, lbpg_pkg::MODE_TRIPLE:
          cnt_nxt = -lbpg_pkg::dur_to_cnt(pulse_len_r);
        lbpg_pkg::MODE_BLIP:
          cnt_nxt = -lbpg_pkg::dur_to_cnt(blip_on_r);
        lbpg_pkg::MODE_SLOW_BLIP:
          cnt_nxt = -lbpg_pkg::dur_to_cnt(slow_blip_on_r);
        default: cnt_nxt = cnt_r;
      endcase
    end else if (tick_fire) begin
      cnt_nxt = cnt_inc;
      unique case (mode_r) inside
        lbpg_pkg::MODE_SINGLE: begin
          if (cnt_inc > lbpg_pkg::cnt_t'(0)) begin
            mode_nxt = lbpg_pkg::MODE_OFF;
          end
        end
        lbpg_pkg::MODE_DOUBLE, lbpg_pkg::MODE_TRIPLE: begin
          // After the gap, drop to one blink fewer and start its on-phase.
          if (cnt_inc > lbpg_pkg::dur_to_cnt(pulse_len_r)) begin
            mode_nxt = lbpg_pkg::mode_t'(mode_r - 4'd1);
            cnt_nxt  = -lbpg_pkg::dur_to_cnt(pulse_len_r);
          end
        end
        lbpg_pkg::MODE_FAST, lbpg_pkg::MODE_BLINK, lbpg_pkg::MODE_SLOW,
        lbpg_pkg::MODE_BLIP, lbpg_pkg::MODE_SLOW_BLIP: begin
          if (cnt_inc > lbpg_pkg::dur_to_cnt(wrap_lim)) begin
            cnt_nxt = -lbpg_pkg::dur_to_cnt(wrap_rst);
          end
        end
        default: ;
      endcase
    end
  end

  // LED level for a tick: steady on and single blink force it lit, off and
  // undefined codes force it dark, all others light it while the counter is
  // negative.
  always_comb begin
    unique case (mode_r) inside
      lbpg_pkg::MODE_ON, lbpg_pkg::MODE_SINGLE:
        led_tick = 1'b1;
      lbpg_pkg::MODE_DOUBLE, lbpg_pkg::MODE_TRIPLE, lbpg_pkg::MODE_FAST,
      lbpg_pkg::MODE_BLINK, lbpg_pkg::MODE_SLOW, lbpg_pkg::MODE_BLIP,
      lbpg_pkg::MODE_SLOW_BLIP:
        led_tick = cnt_nxt[lbpg_pkg::CNT_W-1];
      default:
        led_tick = 1'b0;
    endcase
  end

  // Output register: loads on every tick, empties when the result is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    led_nxt       = led_r;
    if (tick_fire) begin
      out_valid_nxt = 1'b1;
      led_nxt       = led_tick;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lbpg_pkg::MODE_OFF;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    led_r <= led_nxt;
  end

  `LBPG_ASSERT_NEXT(a_tick_gives_result, tick_fire, out_valid_r, "tick without result")
  `LBPG_ASSERT_NEXT(a_set_no_result, in_fire && in_tuser && !out_valid_r, !out_valid_r, "set made a result")
  `LBPG_ASSERT_NOW(a_stall_only_when_full, !in_tready, out_valid_r && !out_tready, "stall while empty")
  `LBPG_ASSERT_NEXT(a_on_is_lit, tick_fire && mode_r == lbpg_pkg::MODE_ON, led_r, "on mode dark")
  `LBPG_ASSERT_NEXT(a_off_is_dark, tick_fire && mode_r == lbpg_pkg::MODE_OFF, !led_r, "off mode lit")

endmodule
